// ===== rtl/core/deq_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the double-ended queue unit.
// No dependencies; used by deq_cell and double_ended_queue_unit.
package deq_pkg;

  localparam int Depth    = 16;
  localparam int WordBits = 32;

  typedef enum logic [2:0] {
    FUNC_PUSH_FRONT = 3'd0,
    FUNC_PUSH_BACK  = 3'd1,
    FUNC_POP_FRONT  = 3'd2,
    FUNC_POP_BACK   = 3'd3,
    FUNC_PEEK_FRONT = 3'd4,
    FUNC_PEEK_BACK  = 3'd5,
    FUNC_CLEAR      = 3'd6,
    FUNC_NOP        = 3'd7
  } func_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_WORD  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_SHIFT_BACK,
    CELL_SHIFT_FRONT,
    CELL_PUSH_TAIL,
    CELL_POP_TAIL,
    CELL_CLEAR
  } cell_op_e;

  typedef struct packed {
    func_e               func;
    logic [WordBits-1:0] push_word;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [WordBits-1:0] read_word;
  } resp_t;

  typedef struct packed {
    cell_op_e            op;
    logic [WordBits-1:0] word;
  } cell_ctrl_t;

endpackage

// ===== rtl/core/deq_cell.sv =====
`timescale 1ns / 1ps
// One queue cell: a stored word plus its occupancy bit, fed by both neighbors.
// Depends on deq_pkg.
module deq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  deq_pkg::cell_ctrl_t          ctrl_i,
  input  logic [deq_pkg::WordBits-1:0] left_word_i,
  input  logic                         left_valid_i,
  input  logic [deq_pkg::WordBits-1:0] right_word_i,
  input  logic                         right_valid_i,
  output logic [deq_pkg::WordBits-1:0] word_o,
  output logic                         valid_o,
  output logic                         tail_o
);

  logic [deq_pkg::WordBits-1:0] word_q, word_d;
  logic                         valid_q, valid_d;

  always_comb begin
    word_d  = word_q;
    valid_d = valid_q;
    unique case (ctrl_i.op)
      deq_pkg::CELL_SHIFT_BACK: begin
        word_d  = left_word_i;
        valid_d = left_valid_i;
      end
      deq_pkg::CELL_SHIFT_FRONT: begin
        word_d  = right_word_i;
        valid_d = right_valid_i;
      end
      deq_pkg::CELL_PUSH_TAIL: begin
        if (!valid_q && left_valid_i) begin
          word_d  = ctrl_i.word;
          valid_d = 1'b1;
        end
      end
      deq_pkg::CELL_POP_TAIL: begin
        if (valid_q && !right_valid_i) valid_d = 1'b0;
      end
      deq_pkg::CELL_CLEAR: valid_d = 1'b0;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o  = word_q;
  assign valid_o = valid_q;
  assign tail_o  = valid_q && !right_valid_i;

endmodule

// ===== rtl/core/double_ended_queue_unit.sv =====
`timescale 1ns / 1ps
// Double-ended queue of words built as a row of shifting cells.
// Depends on deq_pkg and deq_cell.
//
// Usage:
//   in channel : in_valid_i / in_ready_o carry one request word (func, push_word).
//   out channel: out_valid_o / out_ready_i carry one response word per request
//                (status, read_word).
//   Cell 0 holds the front entry; occupancy bits form a thermometer code.
//   Push front / pop front shift the whole row by one cell; push back fills
//   the first free cell and pop back empties the tail cell. Each request
//   updates the row in the cycle it is accepted.
//   Response: registered, and valid in the cycle after acceptance.
//   Throughput: one request per cycle unless the receiver stalls; the limit is
//   the single response register, refilled in the cycle the next request is taken.
//   Receiver stall: while out_valid_o is high and out_ready_i is low the
//   response holds and in_ready_o is low, so no request is accepted.
//   Reset: all occupancy bits clear (queue empty), no response pending.
//   Stored words are not cleared and are never read before written.
module double_ended_queue_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  deq_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output deq_pkg::resp_t out_resp_o
);

  localparam int Depth = deq_pkg::Depth;
  localparam int WB    = deq_pkg::WordBits;

  logic [WB-1:0]    word_w [Depth];
  logic [Depth-1:0] valid_w;
  logic [Depth-1:0] tail_w;

  deq_pkg::cell_ctrl_t ctrl;
  deq_pkg::resp_t      resp_d, resp_q;
  logic                out_valid_q;
  logic                accept, empty, full;
  logic [WB-1:0]       back_word;

  assign accept     = in_valid_i && in_ready_o;
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign empty      = !valid_w[0];
  assign full       = valid_w[Depth-1];

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    deq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_word_i  ((i == 0) ? in_req_i.push_word : word_w[(i == 0) ? 0 : i-1]),
      .left_valid_i ((i == 0) ? 1'b1 : valid_w[(i == 0) ? 0 : i-1]),
      .right_word_i ((i == Depth-1) ? '0 : word_w[(i == Depth-1) ? i : i+1]),
      .right_valid_i((i == Depth-1) ? 1'b0 : valid_w[(i == Depth-1) ? i : i+1]),
      .word_o       (word_w[i]),
      .valid_o      (valid_w[i]),
      .tail_o       (tail_w[i])
    );
  end

  always_comb begin
    back_word = '0;
    for (int i = 0; i < Depth; i++) begin
      back_word = back_word | (tail_w[i] ? word_w[i] : '0);
    end
  end

  always_comb begin
    ctrl.op          = deq_pkg::CELL_HOLD;
    ctrl.word        = in_req_i.push_word;
    resp_d.status    = deq_pkg::ST_OK;
    resp_d.read_word = '0;
    unique case (in_req_i.func)
      deq_pkg::FUNC_PUSH_FRONT, deq_pkg::FUNC_PUSH_BACK: begin
        if (full) begin
          resp_d.status = deq_pkg::ST_FULL;
        end else if (in_req_i.func == deq_pkg::FUNC_PUSH_FRONT) begin
          ctrl.op = deq_pkg::CELL_SHIFT_BACK;
        end else begin
          ctrl.op = deq_pkg::CELL_PUSH_TAIL;
        end
      end
      deq_pkg::FUNC_POP_FRONT, deq_pkg::FUNC_PEEK_FRONT: begin
        if (empty) begin
          resp_d.status = deq_pkg::ST_EMPTY;
        end else begin
          resp_d.status    = deq_pkg::ST_WORD;
          resp_d.read_word = word_w[0];
          if (in_req_i.func == deq_pkg::FUNC_POP_FRONT) ctrl.op = deq_pkg::CELL_SHIFT_FRONT;
        end
      end
      deq_pkg::FUNC_POP_BACK, deq_pkg::FUNC_PEEK_BACK: begin
        if (empty) begin
          resp_d.status = deq_pkg::ST_EMPTY;
        end else begin
          resp_d.status    = deq_pkg::ST_WORD;
          resp_d.read_word = back_word;
          if (in_req_i.func == deq_pkg::FUNC_POP_BACK) ctrl.op = deq_pkg::CELL_POP_TAIL;
        end
      end
      deq_pkg::FUNC_CLEAR: ctrl.op = deq_pkg::CELL_CLEAR;
      default: ;
    endcase
    if (!accept) ctrl.op = deq_pkg::CELL_HOLD;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) resp_q <= resp_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_resp_o  = resp_q;

  // occupancy stays a thermometer code
  a_thermo : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_w & ~{valid_w[Depth-2:0], 1'b1}) == '0)
    else $error("occupancy bits not contiguous from the front");

  a_push_grows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !full && (in_req_i.func == deq_pkg::FUNC_PUSH_FRONT ||
                        in_req_i.func == deq_pkg::FUNC_PUSH_BACK)
    |=> $countones(valid_w) == $past($countones(valid_w)) + 1)
    else $error("push did not add exactly one entry");

  a_pop_shrinks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !empty && (in_req_i.func == deq_pkg::FUNC_POP_FRONT ||
                         in_req_i.func == deq_pkg::FUNC_POP_BACK)
    |=> $countones(valid_w) + 1 == $past($countones(valid_w)))
    else $error("pop did not remove exactly one entry");

  a_word_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && resp_q.status != deq_pkg::ST_WORD |-> resp_q.read_word == '0)
    else $error("read word nonzero without a returned word");

endmodule
